// ===== hw/rtl/thp_pkg.sv =====
// shared types, constants and arithmetic helpers for the sensor compensation block
package thp_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_COEFFS    = 3'd0,
		REG_PRESS_COEFFS_A = 3'd1,
		REG_PRESS_COEFFS_B = 3'd2,
		REG_PRESS_COEFFS_C = 3'd3,
		REG_HUM_COEFFS_A   = 3'd4,
		REG_HUM_COEFFS_B   = 3'd5
	} thp_reg_idx_t;

	localparam logic [31:0] TEMP_ROUND    = 32'd128;
	localparam logic [63:0] PRESS_OFFSET  = 64'd128000;
	localparam logic [63:0] PRESS_FULL    = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE   = 64'd3125;
	localparam logic [63:0] PRESS_BIAS    = 64'd1 << 47;
	localparam logic [31:0] HUM_OFFSET    = 32'd76800;
	localparam logic [31:0] HUM_ROUND_A   = 32'd16384;
	localparam logic [31:0] HUM_BIAS_B    = 32'd2097152;
	localparam logic [31:0] HUM_BIAS_C    = 32'd32768;
	localparam logic [31:0] HUM_ROUND_B   = 32'd8192;
	localparam logic [31:0] HUM_MAX       = 32'd419430400;
	localparam logic [6:0]  HUM_PERCENT   = 7'd100;

	// decoded calibration words, raw bits
	typedef struct packed {
		logic [15:0] t1, t2, t3;
		logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [15:0] h4, h5;
		logic [7:0]  h6;
	} thp_coeffs_t;

	// one job handed from the front to the back
	typedef struct packed {
		logic [31:0] temp;
		logic [63:0] num;
		logic [63:0] den;
		logic [13:0] hum;
		logic        err;
	} thp_job_t;

	function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
		return 64'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(logic [15:0] x);
		return {{16{x[15]}}, x};
	endfunction

	function automatic logic [31:0] sx8(logic [7:0] x);
		return {{24{x[7]}}, x};
	endfunction

	// low 64 bits of a by a signed 16-bit coefficient
	function automatic logic [63:0] mul64s16(logic [63:0] a, logic [15:0] c);
		return 64'($signed(a) * $signed(c));
	endfunction

	// low 64 bits of a by an unsigned 16-bit coefficient
	function automatic logic [63:0] mul64u16(logic [63:0] a, logic [15:0] c);
		return 64'($signed(a) * $signed({1'b0, c}));
	endfunction

	// narrow signed operand (34 bits) by a signed operand, 64-bit result
	function automatic logic [63:0] mul34s16(logic [33:0] a, logic [15:0] c);
		return 64'($signed(a) * $signed(c));
	endfunction

	function automatic logic [63:0] sqr34(logic [33:0] a);
		return 64'($signed(a) * $signed(a));
	endfunction

endpackage

// ===== hw/rtl/thp_if.sv =====
// handshake channels: raw readings, compensated results and register writes
interface thp_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_temperature;
	logic [19:0] raw_pressure;
	logic [15:0] raw_humidity;
	modport source(output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
	modport sink(input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface thp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] temp_centi;
	logic [31:0]        pressure_pa;
	logic [13:0]        humidity_centi;
	logic               error;
	modport source(output valid, temp_centi, pressure_pa, humidity_centi, error, input ready);
	modport sink(input valid, temp_centi, pressure_pa, humidity_centi, error, output ready);
endinterface

interface thp_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [thp_pkg::CFG_IDX_W-1:0]        index;
	logic [thp_pkg::CFG_DATA_W-1:0]       data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/thp_front.sv =====
// front pipeline: temperature, humidity and the pressure dividend and divisor
module thp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	thp_in_if.sink               sample,
	input  thp_pkg::thp_coeffs_t coeffs,
	input  logic                 full,
	output logic                 push,
	output thp_pkg::thp_job_t    job
);

	localparam int unsigned NS = 13;

	logic [NS:1] vld_s;
	logic        en;

	logic [19:0] at_s1, ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7;
	logic [15:0] ah_s1, ah_s2, ah_s3, ah_s4, ah_s5;
	logic [31:0] ma_s2, mb_s2, a_s3, b1_s3, tf_s4;
	logic [31:0] temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10, temp_s11;
	logic [31:0] temp_s12, temp_s13;
	logic [63:0] sq_s5, m5_s5, m2_s5, m5_s6, m2_s6, x2a_s6, x1a_s6;
	logic [31:0] hm5_s5, hv6_s5, hv3_s5, ha_s6, hb1_s6, hb2_s6;
	logic [63:0] x2_s7, x1b_s7, x1c_s8, num0_s8, x1d_s9, num_s9;
	logic [31:0] ha_s7, hb_s7, ha_s8, hb3_s8, ha_s9, hb4_s9;
	logic [63:0] den_s10, num_s10, den_s11, num_s11, den_s12, num_s12, den_s13, num_s13;
	logic [31:0] hv_s10, hv_s11, hsq_s11, hv_s12;
	logic        err_s10, err_s11, err_s12, err_s13;
	logic [13:0] hum_s13;

	logic [31:0] ta, tb, hv_a, hv_c;
	logic [63:0] x1;
	logic [31:0] hv_t;
	logic [26:0] hum_prod;

	assign en           = !vld_s[NS] || !full;
	assign sample.ready = en;
	assign push         = vld_s[NS] && !full;

	always_comb begin
		ta   = {15'b0, at_s1[19:3]} - {15'b0, coeffs.t1, 1'b0};
		tb   = {16'b0, at_s1[19:4]} - {16'b0, coeffs.t1};
		x1   = {{32{tf_s4[31]}}, tf_s4} - thp_pkg::PRESS_OFFSET;
		hv_t = tf_s4 - thp_pkg::HUM_OFFSET;
		hv_a = thp_pkg::asr32(hv_s10, 15);
		// clamp to the valid humidity range
		if (hv_s12[31]) begin
			hv_c = '0;
		end else if (hv_s12 > thp_pkg::HUM_MAX) begin
			hv_c = thp_pkg::HUM_MAX;
		end else begin
			hv_c = hv_s12;
		end
		hum_prod = 27'(hv_c[31:12] * thp_pkg::HUM_PERCENT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], sample.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			at_s1 <= sample.raw_temperature;
			ap_s1 <= sample.raw_pressure;
			ah_s1 <= sample.raw_humidity;

			ma_s2 <= ta * thp_pkg::sx16(coeffs.t2);
			mb_s2 <= tb * tb;
			ap_s2 <= ap_s1;
			ah_s2 <= ah_s1;

			a_s3  <= thp_pkg::asr32(ma_s2, 11);
			b1_s3 <= thp_pkg::asr32(mb_s2, 12) * thp_pkg::sx16(coeffs.t3);
			ap_s3 <= ap_s2;
			ah_s3 <= ah_s2;

			tf_s4 <= a_s3 + thp_pkg::asr32(b1_s3, 14);
			ap_s4 <= ap_s3;
			ah_s4 <= ah_s3;

			temp_s5 <= thp_pkg::asr32((tf_s4 << 2) + tf_s4 + thp_pkg::TEMP_ROUND, 8);
			sq_s5   <= thp_pkg::sqr34(x1[33:0]);
			m5_s5   <= thp_pkg::mul34s16(x1[33:0], coeffs.p5);
			m2_s5   <= thp_pkg::mul34s16(x1[33:0], coeffs.p2);
			hm5_s5  <= thp_pkg::sx16(coeffs.h5) * hv_t;
			hv6_s5  <= hv_t * thp_pkg::sx8(coeffs.h6);
			hv3_s5  <= hv_t * {24'b0, coeffs.h3};
			ap_s5   <= ap_s4;
			ah_s5   <= ah_s4;

			temp_s6 <= temp_s5;
			x2a_s6  <= thp_pkg::mul64s16(sq_s5, coeffs.p6);
			x1a_s6  <= thp_pkg::mul64s16(sq_s5, coeffs.p3);
			m5_s6   <= m5_s5;
			m2_s6   <= m2_s5;
			ha_s6   <= thp_pkg::asr32({2'b0, ah_s5, 14'b0}
				- (thp_pkg::sx16(coeffs.h4) << 20) - hm5_s5 + thp_pkg::HUM_ROUND_A, 15);
			hb1_s6  <= thp_pkg::asr32(hv6_s5, 10);
			hb2_s6  <= thp_pkg::asr32(hv3_s5, 11) + thp_pkg::HUM_BIAS_C;
			ap_s6   <= ap_s5;

			temp_s7 <= temp_s6;
			x2_s7   <= x2a_s6 + (m5_s6 << 17) + ({{48{coeffs.p4[15]}}, coeffs.p4} << 35);
			x1b_s7  <= thp_pkg::asr64(x1a_s6, 8) + (m2_s6 << 12);
			hb_s7   <= hb1_s6 * hb2_s6;
			ha_s7   <= ha_s6;
			ap_s7   <= ap_s6;

			temp_s8 <= temp_s7;
			x1c_s8  <= thp_pkg::mul64u16(thp_pkg::PRESS_BIAS + x1b_s7, coeffs.p1);
			num0_s8 <= ((thp_pkg::PRESS_FULL - {44'b0, ap_s7}) << 31) - x2_s7;
			hb3_s8  <= thp_pkg::asr32(hb_s7, 10);
			ha_s8   <= ha_s7;

			temp_s9 <= temp_s8;
			x1d_s9  <= thp_pkg::asr64(x1c_s8, 33);
			num_s9  <= num0_s8 * thp_pkg::PRESS_SCALE;
			hb4_s9  <= (hb3_s8 + thp_pkg::HUM_BIAS_B) * thp_pkg::sx16(coeffs.h2)
				+ thp_pkg::HUM_ROUND_B;
			ha_s9   <= ha_s8;

			temp_s10 <= temp_s9;
			den_s10  <= x1d_s9;
			num_s10  <= num_s9;
			err_s10  <= (x1d_s9 == '0);
			hv_s10   <= ha_s9 * thp_pkg::asr32(hb4_s9, 14);

			temp_s11 <= temp_s10;
			den_s11  <= den_s10;
			num_s11  <= num_s10;
			err_s11  <= err_s10;
			hv_s11   <= hv_s10;
			hsq_s11  <= hv_a * hv_a;

			temp_s12 <= temp_s11;
			den_s12  <= den_s11;
			num_s12  <= num_s11;
			err_s12  <= err_s11;
			hv_s12   <= hv_s11
				- thp_pkg::asr32(thp_pkg::asr32(hsq_s11, 7) * {24'b0, coeffs.h1}, 4);

			temp_s13 <= temp_s12;
			den_s13  <= den_s12;
			num_s13  <= num_s12;
			err_s13  <= err_s12;
			hum_s13  <= err_s12 ? '0 : hum_prod[23:10];
		end
	end

	assign job = '{temp: temp_s13, num: num_s13, den: den_s13, hum: hum_s13, err: err_s13};

endmodule

// ===== hw/rtl/thp_queue.sv =====
// small job queue between the front and back pipelines
module thp_queue #(
	parameter int unsigned DEPTH = thp_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  thp_pkg::thp_job_t push_data,
	output logic              full,
	input  logic              pop,
	output thp_pkg::thp_job_t pop_data,
	output logic              empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	thp_pkg::thp_job_t mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/thp_back.sv =====
// back pipeline: signed 64-bit division, pressure correction and the result register
module thp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  thp_pkg::thp_coeffs_t coeffs,
	input  logic                 empty,
	output logic                 pop,
	input  thp_pkg::thp_job_t    job,
	thp_out_if.source            result
);

	localparam int unsigned QW = 64;

	logic en;
	logic out_vld_q;

	// divider stages, one quotient bit each
	logic [QW-1:0] rem_s  [0:QW];
	logic [QW-1:0] dq_s   [0:QW];
	logic [QW-1:0] ad_s   [0:QW];
	logic          sign_s [0:QW];
	logic [31:0]   temp_s [0:QW];
	logic [13:0]   hum_s  [0:QW];
	logic          err_s  [0:QW];
	logic [QW:0]   dvld_s;

	logic [5:1]  pvld_s;
	logic [63:0] p_s1, p_s2, p_s3, p_s4;
	logic [63:0] ll_s2, sq_s3, m8_s2, x2b_s3, x2b_s4, m9_s4, sum_s5;
	logic [31:0] lh_s2;
	logic [31:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5;
	logic [13:0] hum_s1, hum_s2, hum_s3, hum_s4, hum_s5;
	logic        err_s1, err_s2, err_s3, err_s4, err_s5;

	logic [63:0] x2_t, pp_t, pres_t;

	assign en  = !out_vld_q || result.ready;
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s    <= '0;
			pvld_s    <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			dvld_s    <= {dvld_s[QW-1:0], !empty};
			pvld_s    <= {pvld_s[4:1], dvld_s[QW]};
			out_vld_q <= pvld_s[5];
		end
	end

	// entry: take magnitudes, remember the quotient sign
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			dq_s[0]   <= job.num[63] ? 64'(-job.num) : job.num;
			ad_s[0]   <= job.den[63] ? 64'(-job.den) : job.den;
			sign_s[0] <= job.num[63] ^ job.den[63];
			temp_s[0] <= job.temp;
			hum_s[0]  <= job.hum;
			err_s[0]  <= job.err;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [QW:0] trial;
		logic        fits;
		assign trial = {rem_s[k], dq_s[k][QW-1]};
		assign fits  = (trial >= {1'b0, ad_s[k]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= fits ? QW'(trial - {1'b0, ad_s[k]}) : trial[QW-1:0];
				dq_s[k+1]   <= {dq_s[k][QW-2:0], fits};
				ad_s[k+1]   <= ad_s[k];
				sign_s[k+1] <= sign_s[k];
				temp_s[k+1] <= temp_s[k];
				hum_s[k+1]  <= hum_s[k];
				err_s[k+1]  <= err_s[k];
			end
		end
	end

	always_comb begin
		x2_t   = thp_pkg::asr64(p_s1, 13);
		pp_t   = thp_pkg::asr64(sum_s5, 8) + ({{48{coeffs.p7[15]}}, coeffs.p7} << 4);
		pres_t = thp_pkg::asr64(pp_t, 8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= sign_s[QW] ? 64'(-dq_s[QW]) : dq_s[QW];
			temp_s1 <= temp_s[QW];
			hum_s1  <= hum_s[QW];
			err_s1  <= err_s[QW];

			// square of p >> 13 from 32-bit halves
			ll_s2   <= {32'b0, x2_t[31:0]} * {32'b0, x2_t[31:0]};
			lh_s2   <= x2_t[31:0] * x2_t[63:32];
			m8_s2   <= thp_pkg::mul64s16(p_s1, coeffs.p8);
			p_s2    <= p_s1;
			temp_s2 <= temp_s1;
			hum_s2  <= hum_s1;
			err_s2  <= err_s1;

			sq_s3   <= ll_s2 + {lh_s2[30:0], 33'b0};
			x2b_s3  <= thp_pkg::asr64(m8_s2, 19);
			p_s3    <= p_s2;
			temp_s3 <= temp_s2;
			hum_s3  <= hum_s2;
			err_s3  <= err_s2;

			m9_s4   <= thp_pkg::mul64s16(sq_s3, coeffs.p9);
			x2b_s4  <= x2b_s3;
			p_s4    <= p_s3;
			temp_s4 <= temp_s3;
			hum_s4  <= hum_s3;
			err_s4  <= err_s3;

			sum_s5  <= p_s4 + thp_pkg::asr64(m9_s4, 25) + x2b_s4;
			temp_s5 <= temp_s4;
			hum_s5  <= hum_s4;
			err_s5  <= err_s4;

			result.temp_centi     <= temp_s5;
			result.pressure_pa    <= err_s5 ? '0 : pres_t[31:0];
			result.humidity_centi <= hum_s5;
			result.error          <= err_s5;
		end
	end

	assign result.valid = out_vld_q;

endmodule

// ===== hw/rtl/thp_sensor_compensation_top.sv =====
// top level: calibration registers, front pipeline, job queue and back pipeline
// throughput: one reading per cycle while the result sink does not stall, set by the fully pipelined 64-stage divider
// the queue lets the front keep accepting while the back is stalled by the sink, until the queue is full
// reset: arst_n clears all valid bits, the queue and the calibration registers to zero
// calibration writes are taken every cycle and should only happen while idle
module thp_sensor_compensation_top #(
	parameter int unsigned QUEUE_DEPTH = thp_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	thp_in_if.sink    sample,
	thp_out_if.source result,
	thp_cfg_if.sink   cfg
);

	// calibration words as written
	logic [47:0] temp_coeffs_q;
	logic [47:0] press_coeffs_a_q;
	logic [47:0] press_coeffs_b_q;
	logic [47:0] press_coeffs_c_q;
	logic [31:0] hum_coeffs_a_q;
	logic [39:0] hum_coeffs_b_q;

	thp_pkg::thp_coeffs_t coeffs;
	thp_pkg::thp_job_t    push_job, pop_job;
	logic                 push, pop, full, empty;

	// the register port never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q    <= '0;
			press_coeffs_a_q <= '0;
			press_coeffs_b_q <= '0;
			press_coeffs_c_q <= '0;
			hum_coeffs_a_q   <= '0;
			hum_coeffs_b_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				thp_pkg::REG_TEMP_COEFFS:    temp_coeffs_q    <= cfg.data;
				thp_pkg::REG_PRESS_COEFFS_A: press_coeffs_a_q <= cfg.data;
				thp_pkg::REG_PRESS_COEFFS_B: press_coeffs_b_q <= cfg.data;
				thp_pkg::REG_PRESS_COEFFS_C: press_coeffs_c_q <= cfg.data;
				thp_pkg::REG_HUM_COEFFS_A:   hum_coeffs_a_q   <= cfg.data[31:0];
				thp_pkg::REG_HUM_COEFFS_B:   hum_coeffs_b_q   <= cfg.data[39:0];
				default: begin
					// unused indices are dropped
				end
			endcase
		end
	end

	// split the packed words into coefficient fields
	always_comb begin
		coeffs.t1 = temp_coeffs_q[15:0];
		coeffs.t2 = temp_coeffs_q[31:16];
		coeffs.t3 = temp_coeffs_q[47:32];
		coeffs.p1 = press_coeffs_a_q[15:0];
		coeffs.p2 = press_coeffs_a_q[31:16];
		coeffs.p3 = press_coeffs_a_q[47:32];
		coeffs.p4 = press_coeffs_b_q[15:0];
		coeffs.p5 = press_coeffs_b_q[31:16];
		coeffs.p6 = press_coeffs_b_q[47:32];
		coeffs.p7 = press_coeffs_c_q[15:0];
		coeffs.p8 = press_coeffs_c_q[31:16];
		coeffs.p9 = press_coeffs_c_q[47:32];
		coeffs.h1 = hum_coeffs_a_q[7:0];
		coeffs.h2 = hum_coeffs_a_q[23:8];
		coeffs.h3 = hum_coeffs_a_q[31:24];
		coeffs.h4 = hum_coeffs_b_q[15:0];
		coeffs.h5 = hum_coeffs_b_q[31:16];
		coeffs.h6 = hum_coeffs_b_q[39:32];
	end

	// front: temperature, humidity, pressure dividend and divisor, zero-divisor flag
	thp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.coeffs (coeffs),
		.full   (full),
		.push   (push),
		.job    (push_job)
	);

	// decouples the two halves so each can stall on its own
	thp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_job),
		.empty     (empty)
	);

	// back: division, pressure correction and output register
	thp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.coeffs (coeffs),
		.empty  (empty),
		.pop    (pop),
		.job    (pop_job),
		.result (result)
	);

endmodule

// ===== bench/tb_thp_sensor_compensation_top.sv =====
// testbench for the sensor compensation block: directed table, random readings, predictor check
module tb_thp_sensor_compensation_top;

	logic clk;
	logic arst_n;

	thp_in_if  sample_ch();
	thp_out_if result_ch();
	thp_cfg_if cfg_ch();

	thp_sensor_compensation_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch.sink),
		.result(result_ch.source),
		.cfg(cfg_ch.sink)
	);

	typedef struct {
		logic [31:0] temp_centi;
		logic [31:0] pressure_pa;
		logic [13:0] humidity_centi;
		logic        error;
	} comp_result_t;

	typedef struct {
		logic [19:0] rt;
		logic [19:0] rp;
		logic [15:0] rh;
		bit          known;   // expected result typed in below
		comp_result_t res;
	} reading_row_t;

	// calibration shadow held by the bench
	logic [47:0] cal_shadow [6];

	comp_result_t expected_q[$];
	int  failures;
	int  idle_cycles;
	bit  hold_off;      // long receiver stall requested by the stimulus
	int  hold_len;

	// ---------------------------------------------------------------
	// predictor, written straight from the integer compensation
	// ---------------------------------------------------------------
	function automatic logic [63:0] sdiv_trunc(logic [63:0] n, logic [63:0] d);
		logic [63:0] an, ad, q;
		an = n[63] ? -n : n;
		ad = d[63] ? -d : d;
		q  = an / ad;
		return (n[63] != d[63]) ? -q : q;
	endfunction

	function automatic comp_result_t compensate(logic [19:0] rt, logic [19:0] rp,
			logic [15:0] rh);
		comp_result_t r;
		logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] a, b, tf, v, at, ah;
		logic [63:0] x1, x2, p;
		at = {12'd0, rt};
		ah = {16'd0, rh};
		t1 = {16'd0, cal_shadow[0][15:0]};
		t2 = {{16{cal_shadow[0][31]}}, cal_shadow[0][31:16]};
		t3 = {{16{cal_shadow[0][47]}}, cal_shadow[0][47:32]};
		p1 = {48'd0, cal_shadow[1][15:0]};
		p2 = {{48{cal_shadow[1][31]}}, cal_shadow[1][31:16]};
		p3 = {{48{cal_shadow[1][47]}}, cal_shadow[1][47:32]};
		p4 = {{48{cal_shadow[2][15]}}, cal_shadow[2][15:0]};
		p5 = {{48{cal_shadow[2][31]}}, cal_shadow[2][31:16]};
		p6 = {{48{cal_shadow[2][47]}}, cal_shadow[2][47:32]};
		p7 = {{48{cal_shadow[3][15]}}, cal_shadow[3][15:0]};
		p8 = {{48{cal_shadow[3][31]}}, cal_shadow[3][31:16]};
		p9 = {{48{cal_shadow[3][47]}}, cal_shadow[3][47:32]};
		h1 = {24'd0, cal_shadow[4][7:0]};
		h2 = {{16{cal_shadow[4][23]}}, cal_shadow[4][23:8]};
		h3 = {24'd0, cal_shadow[4][31:24]};
		h4 = {{16{cal_shadow[5][15]}}, cal_shadow[5][15:0]};
		h5 = {{16{cal_shadow[5][31]}}, cal_shadow[5][31:16]};
		h6 = {{24{cal_shadow[5][39]}}, cal_shadow[5][39:32]};

		// temperature
		a  = 32'(((at >> 3) - (t1 << 1)) * t2);
		a  = $signed(a) >>> 11;
		b  = (at >> 4) - t1;
		b  = 32'(b * b);
		b  = $signed(b) >>> 12;
		b  = 32'(b * t3);
		b  = $signed(b) >>> 14;
		tf = a + b;
		r.temp_centi = 32'($signed(32'(tf * 5 + 128)) >>> 8);

		// pressure
		x1 = {{32{tf[31]}}, tf} - 64'd128000;
		x2 = 64'(x1 * x1 * p6);
		x2 = x2 + 64'(64'(x1 * p5) << 17);
		x2 = x2 + 64'(p4 << 35);
		p  = 64'(x1 * x1 * p3);
		x1 = 64'($signed(p) >>> 8) + 64'(64'(x1 * p2) << 12);
		p  = 64'((64'd1 << 47) + x1);
		p  = 64'(p * p1);
		x1 = $signed(p) >>> 33;
		r.error = (x1 == 64'd0);
		r.pressure_pa = '0;
		r.humidity_centi = '0;
		if (!r.error) begin
			p  = 64'd1048576 - {44'd0, rp};
			p  = sdiv_trunc(64'((64'(p << 31) - x2) * 64'd3125), x1);
			x2 = $signed(p) >>> 13;
			x1 = 64'(p9 * x2 * x2);
			x1 = $signed(x1) >>> 25;
			x2 = 64'(p8 * p);
			x2 = $signed(x2) >>> 19;
			p  = 64'(p + x1 + x2);
			p  = 64'($signed(p) >>> 8) + 64'(p7 << 4);
			p  = $signed(p) >>> 8;
			r.pressure_pa = p[31:0];

			// humidity
			v = tf - 32'd76800;
			a = 32'((ah << 14) - (h4 << 20) - 32'(h5 * v) + 32'd16384);
			a = $signed(a) >>> 15;
			b = 32'(v * h6);
			b = $signed(b) >>> 10;
			tf = 32'(v * h3);
			tf = 32'($signed(tf) >>> 11) + 32'd32768;
			b = 32'(b * tf);
			b = $signed(b) >>> 10;
			b = 32'((b + 32'd2097152) * h2 + 32'd8192);
			b = $signed(b) >>> 14;
			v = 32'(a * b);
			a = $signed(v) >>> 15;
			tf = 32'(a * a);
			tf = $signed(tf) >>> 7;
			tf = 32'(tf * h1);
			tf = $signed(tf) >>> 4;
			v = v - tf;
			if (v[31])
				v = 0;
			else if (v > 32'd419430400)
				v = 32'd419430400;
			v = ((v >> 12) * 32'd100) / 32'd1024;
			r.humidity_centi = v[13:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// clock, reset, watchdog
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// cycles with no beat on any channel
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// result side: random stall, long hold-off on request, checking
	// ---------------------------------------------------------------
	initial begin
		int gap;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected");
					failures++;
				end else begin
					comp_result_t e;
					e = expected_q.pop_front();
					if (result_ch.temp_centi !== e.temp_centi) begin
						$error("temp_centi exp %0d got %0d", $signed(e.temp_centi),
							result_ch.temp_centi);
						failures++;
					end
					if (result_ch.pressure_pa !== e.pressure_pa) begin
						$error("pressure_pa exp %0d got %0d", e.pressure_pa,
							result_ch.pressure_pa);
						failures++;
					end
					if (result_ch.humidity_centi !== e.humidity_centi) begin
						$error("humidity_centi exp %0d got %0d", e.humidity_centi,
							result_ch.humidity_centi);
						failures++;
					end
					if (result_ch.error !== e.error) begin
						$error("error exp %0d got %0d", e.error, result_ch.error);
						failures++;
					end
				end
			end
			if (hold_off) begin
				// long hold-off while the sender keeps offering readings
				result_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_off = 1'b0;
				result_ch.ready <= 1'b1;
			end else if (gap > 0) begin
				gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				// mostly no stall, sometimes short, rarely long
				case ($urandom_range(0, 19))
					0, 1, 2: gap = $urandom_range(1, 3);
					3:       gap = $urandom_range(10, 60);
					default: gap = 0;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	// valid stays high across back-to-back writes; the caller drops it
	task automatic cal_write(thp_pkg::thp_reg_idx_t idx, logic [47:0] val);
		logic [47:0] m;
		m = (idx == thp_pkg::REG_HUM_COEFFS_A) ? 48'hFFFF_FFFF :
			(idx == thp_pkg::REG_HUM_COEFFS_B) ? 48'hFF_FFFF_FFFF : '1;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cal_shadow[idx] = val & m;
	endtask

	// wait for every expected result, plus the block latency
	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// offer one reading, with a random gap before it when gaps is set; valid stays high across beats
	task automatic send_reading(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh,
			bit gaps);
		int gap;
		gap = 0;
		if (gaps)
			case ($urandom_range(0, 19))
				0, 1, 2: gap = $urandom_range(1, 3);
				3:       gap = $urandom_range(10, 50);
				default: gap = 0;
			endcase
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.raw_temperature <= rt;
		sample_ch.raw_pressure    <= rp;
		sample_ch.raw_humidity    <= rh;
		do @(posedge clk); while (!sample_ch.ready);
		expected_q.push_back(compensate(rt, rp, rh));
	endtask

	task automatic random_cal();
		thp_pkg::thp_reg_idx_t idx;
		for (int i = 0; i < 6; i++) begin
			idx = thp_pkg::thp_reg_idx_t'(i);
			cal_write(idx, 48'({$urandom, $urandom}));
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// plausible sensor calibration with random jitter
	task automatic typical_cal();
		cal_write(thp_pkg::REG_TEMP_COEFFS, {16'($urandom_range(0, 100)) - 16'd50,
			16'd26000 + 16'($urandom_range(0, 1000)), 16'd27000 + 16'($urandom_range(0, 2000))});
		cal_write(thp_pkg::REG_PRESS_COEFFS_A, {16'd3024, 16'hD6D0 + 16'($urandom_range(0, 200)),
			16'd36000 + 16'($urandom_range(0, 2000))});
		cal_write(thp_pkg::REG_PRESS_COEFFS_B, {16'hFFF9, 16'h0010 + 16'($urandom_range(0, 100)),
			16'd7000 + 16'($urandom_range(0, 1000))});
		cal_write(thp_pkg::REG_PRESS_COEFFS_C, {16'd4285, 16'hD5A0, 16'h0010});
		cal_write(thp_pkg::REG_HUM_COEFFS_A, {8'h00, 16'd360 + 16'($urandom_range(0, 40)),
			8'($urandom_range(50, 100))});
		cal_write(thp_pkg::REG_HUM_COEFFS_B, {8'h1E, 16'd50,
			16'd320 + 16'($urandom_range(0, 40))});
		cfg_ch.valid <= 1'b0;
	endtask

	reading_row_t table_rows[$];

	initial begin
		reading_row_t row;
		comp_result_t zero_res;
		int n_items;
		failures = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		hold_len = 0;
		for (int i = 0; i < 6; i++) cal_shadow[i] = '0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_temperature = '0;
		sample_ch.raw_pressure = '0;
		sample_ch.raw_humidity = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = thp_pkg::REG_TEMP_COEFFS;
		cfg_ch.data = '0;
		@(posedge arst_n);
		@(posedge clk);

		// after reset every coefficient is zero: p1 is zero, so the divisor is zero
		zero_res = '{temp_centi: 32'd0, pressure_pa: 32'd0, humidity_centi: 14'd0,
			error: 1'b1};
		row = '{rt: 20'd0, rp: 20'd0, rh: 16'd0, known: 1'b1, res: zero_res};
		table_rows.push_back(row);
		row.rt = 20'hFFFFF; row.rp = 20'hFFFFF; row.rh = 16'hFFFF;
		table_rows.push_back(row);
		foreach (table_rows[i]) begin
			send_reading(table_rows[i].rt, table_rows[i].rp, table_rows[i].rh, 1'b0);
			// typed expectation replaces the predicted one
			if (table_rows[i].known) begin
				void'(expected_q.pop_back());
				expected_q.push_back(table_rows[i].res);
			end
		end
		sample_ch.valid <= 1'b0;
		drain();

		// typical calibration: field extremes, checked by the predictor
		typical_cal();
		table_rows.delete();
		row.known = 1'b0;
		for (int i = 0; i < 8; i++) begin
			row.rt = (i & 1) ? 20'hFFFFF : ((i & 4) ? 20'd519888 : 20'd0);
			row.rp = (i & 2) ? 20'hFFFFF : ((i & 4) ? 20'd415148 : 20'd0);
			row.rh = (i & 1) ? 16'hFFFF : ((i & 2) ? 16'd0 : 16'd30000);
			table_rows.push_back(row);
		end
		foreach (table_rows[i])
			send_reading(table_rows[i].rt, table_rows[i].rp, table_rows[i].rh, 1'b0);
		sample_ch.valid <= 1'b0;
		drain();

		// extreme calibration words: all ones, then sign bits only, then all bits but the sign bits
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 6; i++)
				cal_write(thp_pkg::thp_reg_idx_t'(i), (k == 0) ? '1 :
					(k == 1) ? 48'h8000_8000_8000 : 48'h7FFF_7FFF_7FFF);
			cfg_ch.valid <= 1'b0;
			send_reading(20'd0, 20'd0, 16'd0, 1'b0);
			send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
			send_reading(20'h80000, 20'h7FFFF, 16'h8000, 1'b0);
			sample_ch.valid <= 1'b0;
			drain();
		end

		// random phases, mostly plausible calibrations
		n_items = 0;
		for (int ph = 0; n_items < 1050; ph++) begin
			if (ph % 4 == 3) random_cal();
			else typical_cal();
			for (int i = 0; i < 150; i++) begin
				logic [19:0] rt, rp;
				logic [15:0] rh;
				if ($urandom_range(0, 3) != 0) begin
					rt = 20'd400000 + 20'($urandom_range(0, 200000));
					rp = 20'd250000 + 20'($urandom_range(0, 300000));
					rh = 16'd20000 + 16'($urandom_range(0, 20000));
				end else begin
					rt = 20'($urandom);
					rp = 20'($urandom);
					rh = 16'($urandom);
				end
				// one long receiver stall per run, early on
				if (ph == 1 && i == 10) begin
					hold_len = 400;
					hold_off = 1'b1;
				end
				send_reading(rt, rp, rh, 1'b1);
				n_items++;
			end
			// sender pauses until every result has come back
			sample_ch.valid <= 1'b0;
			drain();
		end

		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
